// ===== src/sha256_stream_hasher_core_macros.svh =====
// assertion macros for the sha-256 stream hasher
`ifndef SHA256_STREAM_HASHER_CORE_MACROS_SVH
`define SHA256_STREAM_HASHER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define SHS_ASSERT_IMPLIES(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("same-cycle check failed");
`define SHS_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("next-cycle check failed");
`else
`define SHS_ASSERT_IMPLIES(lbl, clk, rst, pre, post)
`define SHS_ASSERT_NEXT(lbl, clk, rst, pre, post)
`endif
`endif

// ===== src/shs_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and functions of the sha-256 stream hasher
package shs_pkg;

   localparam int WORD_W    = 32;
   localparam int NUM_WORDS = 8;
   localparam int COUNT_W   = 61;

   localparam logic [7:0] PAD_MARK = 8'h80;
   localparam logic [5:0] LEN_FILL = 6'd56;

   typedef logic [WORD_W-1:0] word_type;

   typedef struct packed {
      logic load;
      logic step;
      logic fold;
      logic restart;
   } rnd_ctl_type;

   localparam word_type ROUND_K [0:63] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
      32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
      32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
      32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
      32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
      32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
      32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
      32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
      32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   localparam word_type INIT_H [0:NUM_WORDS-1] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   function automatic word_type rotr(input word_type v, input int n);
      return (v >> n) | (v << (WORD_W - n));
   endfunction

endpackage

// ===== src/shs_chan_if.sv =====
`timescale 1ns / 1ps
// request and response channel interfaces of the sha-256 stream hasher
interface shs_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] data_byte;
   modport source (output valid, kind, data_byte, input ready);
   modport sink (input valid, kind, data_byte, output ready);
endinterface

interface shs_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;
   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== src/shs_sched.sv =====
`timescale 1ns / 1ps
// block buffer and message schedule window, filled by bytes, stepped by words
module shs_sched (
   input  logic                clock,
   input  logic                byte_push,
   input  logic [7:0]          byte_val,
   input  logic                word_step,
   output shs_pkg::word_type   w_out
);
   logic [511:0]      win_ff, win_in;
   shs_pkg::word_type w0, w1, w9, w14, s0, s1, w_next;

   assign w0  = win_ff[511:480];
   assign w1  = win_ff[479:448];
   assign w9  = win_ff[223:192];
   assign w14 = win_ff[63:32];
   assign s0  = shs_pkg::rotr(w1, 7) ^ shs_pkg::rotr(w1, 18) ^ (w1 >> 3);
   assign s1  = shs_pkg::rotr(w14, 17) ^ shs_pkg::rotr(w14, 19) ^ (w14 >> 10);
   assign w_next = w0 + s0 + w9 + s1;
   assign w_out  = w0;

   always_comb begin
      win_in = win_ff;
      if (byte_push) begin
         win_in = {win_ff[503:0], byte_val};
      end else if (word_step) begin
         win_in = {win_ff[479:0], w_next};
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end
endmodule

// ===== src/shs_round.sv =====
`timescale 1ns / 1ps
// working variables, one compression round per cycle, and chaining value
module shs_round (
   input  logic                  clock,
   input  logic                  reset,
   input  shs_pkg::rnd_ctl_type  ctl,
   input  shs_pkg::word_type     w_in,
   input  logic [5:0]            rnd_idx,
   input  logic [2:0]            rd_idx,
   output shs_pkg::word_type     rd_word
);
   shs_pkg::word_type v_ff [0:7];
   shs_pkg::word_type v_in [0:7];
   shs_pkg::word_type chain_ff [0:7];
   shs_pkg::word_type chain_in [0:7];
   shs_pkg::word_type sum1, sum0, ch, mj, t1, t2;

   assign sum1 = shs_pkg::rotr(v_ff[4], 6) ^ shs_pkg::rotr(v_ff[4], 11)
               ^ shs_pkg::rotr(v_ff[4], 25);
   assign ch   = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
   assign t1   = v_ff[7] + sum1 + ch + shs_pkg::ROUND_K[rnd_idx] + w_in;
   assign sum0 = shs_pkg::rotr(v_ff[0], 2) ^ shs_pkg::rotr(v_ff[0], 13)
               ^ shs_pkg::rotr(v_ff[0], 22);
   assign mj   = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
   assign t2   = sum0 + mj;
   assign rd_word = chain_ff[rd_idx];

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         v_in[i]     = v_ff[i];
         chain_in[i] = chain_ff[i];
      end
      if (ctl.load) begin
         for (int i = 0; i < 8; i++) begin
            v_in[i] = chain_ff[i];
         end
      end else if (ctl.step) begin
         v_in[7] = v_ff[6];
         v_in[6] = v_ff[5];
         v_in[5] = v_ff[4];
         v_in[4] = v_ff[3] + t1;
         v_in[3] = v_ff[2];
         v_in[2] = v_ff[1];
         v_in[1] = v_ff[0];
         v_in[0] = t1 + t2;
      end
      if (ctl.restart) begin
         for (int i = 0; i < 8; i++) begin
            chain_in[i] = shs_pkg::INIT_H[i];
         end
      end else if (ctl.fold) begin
         for (int i = 0; i < 8; i++) begin
            chain_in[i] = chain_ff[i] + v_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 8; i++) begin
         v_ff[i] <= v_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) begin
            chain_ff[i] <= shs_pkg::INIT_H[i];
         end
      end else begin
         for (int i = 0; i < 8; i++) begin
            chain_ff[i] <= chain_in[i];
         end
      end
   end
endmodule

// ===== src/sha256_stream_hasher_core.sv =====
`timescale 1ns / 1ps
// sha-256 stream hasher top level: sequencer, length counter, output port
// a message byte is taken while idle; the 64th byte of a block starts a compression
// (64 rounds of the shared round unit, then a fold into the chain value)
// end of message feeds the padding bytes, one at a time, through the same path, then
// one or two compressions, then eight digest word transfers, one per cycle while the receiver is ready
// synchronous active-high reset: idle, empty message, initial hash words
`include "sha256_stream_hasher_core_macros.svh"
module sha256_stream_hasher_core (
   input  logic           clock,
   input  logic           reset,
   shs_req_if.sink        req_chan,
   shs_rsp_if.source      rsp_chan
);
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PAD   = 3'd1;
   localparam logic [2:0] ST_ROUND = 3'd2;
   localparam logic [2:0] ST_FOLD  = 3'd3;
   localparam logic [2:0] ST_OUT   = 3'd4;

   localparam logic [1:0] PH_MARK = 2'd0;
   localparam logic [1:0] PH_ZERO = 2'd1;
   localparam logic [1:0] PH_LEN  = 2'd2;

   localparam logic KIND_BYTE = 1'b0;

   logic [2:0]                   state_ff, state_in;
   logic [1:0]                   phase_ff, phase_in;
   logic                         pad_ff, pad_in;
   logic [5:0]                   fill_ff, fill_in;
   logic [5:0]                   rnd_ff, rnd_in;
   logic [2:0]                   lidx_ff, lidx_in;
   logic [2:0]                   oidx_ff, oidx_in;
   logic [shs_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic                         push;
   logic [7:0]                   push_byte;
   logic [63:0]                  bit_len;
   logic [2:0]                   len_sel;
   logic [7:0]                   len_byte;
   logic                         req_xfer, rsp_xfer;
   shs_pkg::rnd_ctl_type         ctl;
   shs_pkg::word_type            w_cur;

   assign bit_len  = {count_ff, 3'b000};
   assign len_sel  = 3'(3'd7 - lidx_ff);
   assign len_byte = bit_len[{len_sel, 3'b000} +: 8];

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid = (state_ff == ST_OUT);
   assign rsp_xfer       = rsp_chan.valid && rsp_chan.ready;
   assign rsp_chan.word_index = oidx_ff;
   assign rsp_chan.last_word  = (oidx_ff == 3'd7);

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      pad_in    = pad_ff;
      fill_in   = fill_ff;
      rnd_in    = rnd_ff;
      lidx_in   = lidx_ff;
      oidx_in   = oidx_ff;
      count_in  = count_ff;
      push      = 1'b0;
      push_byte = req_chan.data_byte;
      ctl       = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_chan.kind == KIND_BYTE) begin
                  push     = 1'b1;
                  count_in = count_ff + 1'b1;
               end else begin
                  pad_in   = 1'b1;
                  phase_in = PH_MARK;
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            case (phase_ff)
               PH_MARK: begin
                  push      = 1'b1;
                  push_byte = shs_pkg::PAD_MARK;
                  phase_in  = PH_ZERO;
               end
               PH_ZERO: begin
                  if (fill_ff == shs_pkg::LEN_FILL) begin
                     phase_in = PH_LEN;
                     lidx_in  = '0;
                  end else begin
                     push      = 1'b1;
                     push_byte = '0;
                  end
               end
               PH_LEN: begin
                  push      = 1'b1;
                  push_byte = len_byte;
                  lidx_in   = lidx_ff + 1'b1;
               end
               default: begin
                  phase_in = PH_MARK;
               end
            endcase
         end
         ST_ROUND: begin
            ctl.step = 1'b1;
            rnd_in   = rnd_ff + 1'b1;
            if (rnd_ff == 6'd63) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            ctl.fold = 1'b1;
            if (pad_ff && phase_ff == PH_LEN) begin
               oidx_in  = '0;
               state_in = ST_OUT;
            end else if (pad_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT: begin
            if (rsp_xfer) begin
               oidx_in = oidx_ff + 1'b1;
               if (oidx_ff == 3'd7) begin
                  ctl.restart = 1'b1;
                  count_in    = '0;
                  pad_in      = 1'b0;
                  state_in    = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (push) begin
         fill_in = fill_ff + 1'b1;
         if (fill_ff == 6'd63) begin
            ctl.load = 1'b1;
            rnd_in   = '0;
            state_in = ST_ROUND;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_MARK;
         pad_ff   <= 1'b0;
         fill_ff  <= '0;
         rnd_ff   <= '0;
         lidx_ff  <= '0;
         oidx_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         pad_ff   <= pad_in;
         fill_ff  <= fill_in;
         rnd_ff   <= rnd_in;
         lidx_ff  <= lidx_in;
         oidx_ff  <= oidx_in;
         count_ff <= count_in;
      end
   end

   shs_sched u_sched (
      .clock     (clock),
      .byte_push (push),
      .byte_val  (push_byte),
      .word_step (ctl.step),
      .w_out     (w_cur)
   );

   shs_round u_round (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .w_in    (w_cur),
      .rnd_idx (rnd_ff),
      .rd_idx  (oidx_ff),
      .rd_word (rsp_chan.digest_word)
   );

   `SHS_ASSERT_IMPLIES(a_out_block_empty, clock, reset, rsp_chan.valid, fill_ff == 6'd0 && pad_ff)
   `SHS_ASSERT_NEXT(a_round_to_fold, clock, reset, state_ff == ST_ROUND && rnd_ff == 6'd63, state_ff == ST_FOLD)
   `SHS_ASSERT_NEXT(a_last_restarts, clock, reset, rsp_xfer && rsp_chan.last_word, state_ff == ST_IDLE && count_ff == '0 && !pad_ff)
   `SHS_ASSERT_IMPLIES(a_one_side_busy, clock, reset, req_chan.ready, !rsp_chan.valid && !pad_ff)
endmodule

// ===== test/sha256_stream_hasher_core_tb.sv =====
`timescale 1ns / 1ps
// testbench of the sha-256 stream hasher: directed and random messages checked against a predictor
module sha256_stream_hasher_core_tb;

   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_END  = 1'b1;
   localparam int   CYCLE_LIMIT = 400000;
   localparam int   ITEM_TARGET = 280;

   typedef struct {
      logic [31:0] word;
      logic [2:0]  idx;
      logic        last;
   } digest_word_type;

   logic clock;
   logic reset;

   shs_req_if req_chan ();
   shs_rsp_if rsp_chan ();

   sha256_stream_hasher_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   localparam logic [31:0] RND_K [0:63] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
      32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
      32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
      32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
      32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
      32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
      32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
      32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
      32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   localparam logic [31:0] IV [0:7] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   logic [31:0]     hash_state [0:7];
   logic [7:0]      byte_buf [0:63];
   logic [5:0]      fill_cnt;
   logic [60:0]     msg_len;
   digest_word_type digest_q [$];

   int errors = 0;
   int items_sent = 0;
   int messages = 0;
   int words_checked = 0;
   int cycles = 0;
   int burst_left = 0;
   int stall_mode = 0;
   logic [15:0] stall_pat = 16'hb5a3;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [31:0] ror(input logic [31:0] v, input int n);
      return (v >> n) | (v << (32 - n));
   endfunction

   task automatic hash_block();
      logic [31:0] w [0:15];
      logic [31:0] v [0:7];
      logic [31:0] x, y, t1, t2;
      for (int i = 0; i < 16; i++)
         w[i] = {byte_buf[4*i], byte_buf[4*i+1], byte_buf[4*i+2], byte_buf[4*i+3]};
      for (int i = 0; i < 8; i++)
         v[i] = hash_state[i];
      for (int t = 0; t < 64; t++) begin
         if (t >= 16) begin
            x = w[(t + 1) & 15];
            y = w[(t + 14) & 15];
            w[t & 15] = w[t & 15] + (ror(x, 7) ^ ror(x, 18) ^ (x >> 3)) + w[(t + 9) & 15]
                        + (ror(y, 17) ^ ror(y, 19) ^ (y >> 10));
         end
         t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
              + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RND_K[t] + w[t & 15];
         t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
              + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++)
         hash_state[i] = hash_state[i] + v[i];
   endtask

   task automatic restart_digest();
      for (int i = 0; i < 8; i++)
         hash_state[i] = IV[i];
      fill_cnt = '0;
      msg_len  = '0;
   endtask

   task automatic predict_item(input logic kind, input logic [7:0] data);
      logic [63:0]     bit_len;
      digest_word_type dw;
      if (kind == KIND_BYTE) begin
         byte_buf[fill_cnt] = data;
         fill_cnt = fill_cnt + 1'b1;
         msg_len  = msg_len + 1'b1;
         if (fill_cnt == 0)
            hash_block();
      end else begin
         byte_buf[fill_cnt] = 8'h80;
         for (int i = fill_cnt + 1; i < 64; i++)
            byte_buf[i] = 8'h00;
         if (fill_cnt >= 56) begin
            hash_block();
            for (int i = 0; i < 56; i++)
               byte_buf[i] = 8'h00;
         end
         bit_len = {msg_len, 3'b000};
         for (int i = 0; i < 8; i++)
            byte_buf[63 - i] = bit_len[8*i +: 8];
         hash_block();
         for (int i = 0; i < 8; i++) begin
            dw.word = hash_state[i];
            dw.idx  = 3'(i);
            dw.last = (i == 7);
            digest_q.push_back(dw);
         end
         messages++;
         restart_digest();
      end
   endtask

   // one request transfer, with bursts and random gaps
   task automatic send_item(input logic kind, input logic [7:0] data);
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) != 0) begin
            req_chan.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_chan.valid     <= 1'b1;
      req_chan.kind      <= kind;
      req_chan.data_byte <= data;
      do
         @(posedge clock);
      while (!req_chan.ready);
      predict_item(kind, data);
      items_sent++;
   endtask

   task automatic send_message(input int len, input int fill_mode);
      for (int i = 0; i < len; i++)
         case (fill_mode)
            0: send_item(KIND_BYTE, 8'h00);
            1: send_item(KIND_BYTE, 8'hff);
            default: send_item(KIND_BYTE, 8'($urandom_range(0, 255)));
         endcase
      send_item(KIND_END, 8'($urandom_range(0, 255)));
   endtask

   task automatic test_directed();
      send_message(0, 2);
      send_item(KIND_BYTE, 8'h61);
      send_item(KIND_BYTE, 8'h62);
      send_item(KIND_BYTE, 8'h63);
      send_item(KIND_END, 8'hff);
      send_message(55, 0);
      send_message(56, 1);
      send_message(63, 2);
      send_message(64, 1);
      send_message(0, 2);
      send_message(1, 1);
   endtask

   task automatic test_random();
      int len;
      while (items_sent < ITEM_TARGET) begin
         case ($urandom_range(0, 9))
            0: len = 0;
            1, 2: len = $urandom_range(54, 66);
            3: len = $urandom_range(100, 140);
            default: len = $urandom_range(1, 40);
         endcase
         if (len > ITEM_TARGET - items_sent - 1)
            len = ITEM_TARGET - items_sent - 1;
         send_message(len, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1) : 2);
      end
   endtask

   // response side: stall pattern and checking
   always @(posedge clock) begin
      digest_word_type exp_w;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            words_checked++;
            if (digest_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected digest word %h", $time, rsp_chan.digest_word);
            end else begin
               exp_w = digest_q.pop_front();
               if (rsp_chan.digest_word !== exp_w.word) begin
                  errors++;
                  $display("%0t: digest_word expected %h actual %h", $time, exp_w.word,
                           rsp_chan.digest_word);
               end
               if (rsp_chan.word_index !== exp_w.idx) begin
                  errors++;
                  $display("%0t: word_index expected %0d actual %0d", $time, exp_w.idx,
                           rsp_chan.word_index);
               end
               if (rsp_chan.last_word !== exp_w.last) begin
                  errors++;
                  $display("%0t: last_word expected %0d actual %0d", $time, exp_w.last,
                           rsp_chan.last_word);
               end
            end
         end
         stall_pat <= {stall_pat[14:0], stall_pat[15] ^ stall_pat[13] ^ stall_pat[12]
                       ^ stall_pat[10]};
         if ($urandom_range(0, 199) == 0)
            stall_mode <= $urandom_range(0, 2);
         case (stall_mode)
            0: rsp_chan.ready <= 1'b1;
            1: rsp_chan.ready <= stall_pat[0] | stall_pat[3];
            default: rsp_chan.ready <= stall_pat[0] & stall_pat[5];
         endcase
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("sha256_stream_hasher_core_tb: errors");
         $finish;
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.kind      = KIND_BYTE;
      req_chan.data_byte = 8'h00;
      rsp_chan.ready     = 1'b0;
      for (int i = 0; i < 64; i++)
         byte_buf[i] = 8'h00;
      restart_digest();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random();
      req_chan.valid <= 1'b0;
      wait (digest_q.size() == 0);
      repeat (200) @(posedge clock);
      $display("ran %0d request items in %0d messages", items_sent, messages);
      $display("checked %0d digest words, %0d mismatches", words_checked, errors);
      if (errors == 0)
         $display("sha256_stream_hasher_core_tb: clean");
      else
         $display("sha256_stream_hasher_core_tb: errors");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+src
src/shs_pkg.sv
src/shs_chan_if.sv
src/shs_sched.sv
src/shs_round.sv
src/sha256_stream_hasher_core.sv
test/sha256_stream_hasher_core_tb.sv
